>>> src/clp_pkg.sv
// Package: constants, keyword tables, result type and match functions for the command line parser.
package clp_pkg;

    localparam int NCmd = 13;
    localparam int NAct = 9;
    localparam int MaxNameLen = 100;
    localparam int NameLenW = 7;
    localparam int ParamW = 31;
    localparam logic [ParamW-1:0] ParamMax = {ParamW{1'b1}};

    localparam logic [7:0] ChEq    = "=";
    localparam logic [7:0] ChDash  = "-";
    localparam logic [7:0] ChGt    = ">";
    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] ChZero  = "0";
    localparam logic [7:0] ChNine  = "9";

    // keywords right-aligned in 64 bits, first character highest
    localparam logic [63:0] CMD_WORDS [NCmd] = '{
        64'("TEST"), 64'("LWHEEL"), 64'("RWHEEL"), 64'("LBRUSH"), 64'("RBRUSH"),
        64'("MBRUSH"), 64'("FAN"), 64'("SENSOR"), 64'("RGB_LED"), 64'("KEY"),
        64'("IRDA"), 64'("BUZZER"), 64'("CHARGE")
    };
    localparam logic [3:0] CMD_LENS [NCmd] = '{
        4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd7, 4'd3, 4'd4, 4'd6, 4'd6
    };
    localparam logic [63:0] ACT_WORDS [NAct] = '{
        64'("ON"), 64'("OFF"), 64'("READ"), 64'("DIR"), 64'("SPEED"),
        64'({"IFRD", "_LED"}), 64'({"B_SW", "ITCH"}), 64'("START"), 64'("STOP")
    };
    localparam logic [3:0] ACT_LENS [NAct] = '{
        4'd2, 4'd3, 4'd4, 4'd3, 4'd5, 4'd8, 4'd8, 4'd5, 4'd4
    };

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CMD = 2'd1,
        ST_BAD_ACT = 2'd2
    } status_t;

    typedef struct packed {
        logic [ParamW-1:0] parameter_res;
        logic [3:0]        action;
        logic [3:0]        command;
        status_t           status;
    } result_t;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic char_hit(input logic [63:0] word, input logic [3:0] len,
                                      input logic [NameLenW-1:0] pos, input logic [7:0] c);
        logic [2:0] k;
        logic [5:0] sh;
        k = 3'(len - 4'd1 - 4'(pos[2:0]));
        sh = {k, 3'b000};
        return ({3'b000, len} > pos) && (word[sh +: 8] == c);
    endfunction

    function automatic logic [NCmd-1:0] cmd_char_mask(input logic [NameLenW-1:0] pos,
                                                      input logic [7:0] c);
        logic [NCmd-1:0] m;
        for (int i = 0; i < NCmd; i++)
            m[i] = char_hit(CMD_WORDS[i], CMD_LENS[i], pos, c);
        return m;
    endfunction

    function automatic logic [NAct-1:0] act_char_mask(input logic [NameLenW-1:0] pos,
                                                      input logic [7:0] c);
        logic [NAct-1:0] m;
        for (int i = 0; i < NAct; i++)
            m[i] = char_hit(ACT_WORDS[i], ACT_LENS[i], pos, c);
        return m;
    endfunction

    function automatic logic [NCmd-1:0] cmd_len_mask(input logic [NameLenW-1:0] len);
        logic [NCmd-1:0] m;
        for (int i = 0; i < NCmd; i++)
            m[i] = ({3'b000, CMD_LENS[i]} == len);
        return m;
    endfunction

    function automatic logic [NAct-1:0] act_len_mask(input logic [NameLenW-1:0] len);
        logic [NAct-1:0] m;
        for (int i = 0; i < NAct; i++)
            m[i] = ({3'b000, ACT_LENS[i]} == len);
        return m;
    endfunction

    // lowest set bit: {found, index}
    function automatic logic [4:0] first_cmd(input logic [NCmd-1:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = NCmd - 1; i >= 0; i--)
            if (v[i])
                r = {1'b1, 4'(i)};
        return r;
    endfunction

    function automatic logic [4:0] first_act(input logic [NAct-1:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = NAct - 1; i >= 0; i--)
            if (v[i])
                r = {1'b1, 4'(i)};
        return r;
    endfunction

endpackage

>>> src/clp_parse.sv
// Per-byte line parser: phase, keyword match vectors, name length and parameter.
module clp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 emit,
    output clp_pkg::result_t     result
);

    typedef enum logic [3:0] {
        PH_CMD   = 4'b0001,
        PH_DASH  = 4'b0010,
        PH_ACT   = 4'b0100,
        PH_PARAM = 4'b1000
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic                             cr_reg, cr_next;
    logic [clp_pkg::NameLenW-1:0]     len_reg, len_next;
    logic [clp_pkg::NCmd-1:0]         cm_reg, cm_next, cm_fin;
    logic [clp_pkg::NAct-1:0]         am_reg, am_next, am_fin;
    logic [clp_pkg::ParamW-1:0]       param_reg, param_next;
    logic                             restart;
    logic                             name_ok;
    logic [34:0]                      prod;
    logic [4:0]                       cfirst, afirst;

    assign name_ok = clp_pkg::is_name_char(rx_byte) &&
                     (len_reg < clp_pkg::NameLenW'(clp_pkg::MaxNameLen));
    assign prod = ({4'b0, param_reg} << 3) + ({4'b0, param_reg} << 1) +
                  35'(rx_byte - clp_pkg::ChZero);

    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        len_next   = len_reg;
        cm_next    = cm_reg;
        am_next    = am_reg;
        param_next = param_reg;
        restart    = 1'b0;
        emit       = 1'b0;
        if (cr_reg)
        begin
            emit    = (rx_byte == clp_pkg::ChLf);
            restart = 1'b1;
        end
        else if (rx_byte == clp_pkg::ChCr)
        begin
            cr_next = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_PARAM:
                begin
                    if (rx_byte >= clp_pkg::ChZero && rx_byte <= clp_pkg::ChNine)
                        param_next = (prod > 35'(clp_pkg::ParamMax)) ?
                                     clp_pkg::ParamMax : prod[clp_pkg::ParamW-1:0];
                    else
                        restart = 1'b1;
                end
                PH_CMD:
                begin
                    if (rx_byte == clp_pkg::ChEq)
                    begin
                        cm_next    = cm_reg & clp_pkg::cmd_len_mask(len_reg);
                        am_next    = am_reg & clp_pkg::act_len_mask('0);
                        phase_next = PH_PARAM;
                        len_next   = '0;
                        param_next = '0;
                    end
                    else if (rx_byte == clp_pkg::ChDash)
                    begin
                        cm_next    = cm_reg & clp_pkg::cmd_len_mask(len_reg);
                        len_next   = '0;
                        phase_next = PH_DASH;
                    end
                    else if (name_ok)
                    begin
                        cm_next  = cm_reg & clp_pkg::cmd_char_mask(len_reg, rx_byte);
                        len_next = len_reg + 1'b1;
                    end
                    else
                        restart = 1'b1;
                end
                PH_DASH:
                begin
                    if (rx_byte == clp_pkg::ChEq)
                    begin
                        am_next    = am_reg & clp_pkg::act_len_mask('0);
                        phase_next = PH_PARAM;
                        len_next   = '0;
                        param_next = '0;
                    end
                    else if (rx_byte == clp_pkg::ChGt)
                        phase_next = PH_ACT;
                    else
                        restart = 1'b1;
                end
                PH_ACT:
                begin
                    if (rx_byte == clp_pkg::ChEq)
                    begin
                        am_next    = am_reg & clp_pkg::act_len_mask(len_reg);
                        phase_next = PH_PARAM;
                        len_next   = '0;
                        param_next = '0;
                    end
                    else if (name_ok)
                    begin
                        am_next  = am_reg & clp_pkg::act_char_mask(len_reg, rx_byte);
                        len_next = len_reg + 1'b1;
                    end
                    else
                        restart = 1'b1;
                end
                default: restart = 1'b1;
            endcase
        end
        if (restart)
        begin
            phase_next = PH_CMD;
            cr_next    = 1'b0;
            len_next   = '0;
            cm_next    = '1;
            am_next    = '1;
            param_next = '0;
        end
    end

    // end-of-line view of the match vectors
    always_comb
    begin
        cm_fin = cm_reg;
        am_fin = am_reg;
        unique case (phase_reg)
            PH_CMD:
            begin
                cm_fin = cm_reg & clp_pkg::cmd_len_mask(len_reg);
                am_fin = am_reg & clp_pkg::act_len_mask('0);
            end
            PH_DASH:  am_fin = am_reg & clp_pkg::act_len_mask('0);
            PH_ACT:   am_fin = am_reg & clp_pkg::act_len_mask(len_reg);
            PH_PARAM: am_fin = am_reg;
            default:  am_fin = am_reg;
        endcase
    end

    assign cfirst = clp_pkg::first_cmd(cm_fin);
    assign afirst = clp_pkg::first_act(am_fin);

    always_comb
    begin
        result = '0;
        if (!cfirst[4])
            result.status = clp_pkg::ST_BAD_CMD;
        else if (!afirst[4])
        begin
            result.status  = clp_pkg::ST_BAD_ACT;
            result.command = cfirst[3:0];
        end
        else
        begin
            result.status        = clp_pkg::ST_OK;
            result.command       = cfirst[3:0];
            result.action        = afirst[3:0];
            result.parameter_res = param_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            cr_reg    <= 1'b0;
            len_reg   <= '0;
            cm_reg    <= '1;
            am_reg    <= '1;
            param_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            len_reg   <= len_next;
            cm_reg    <= cm_next;
            am_reg    <= am_next;
            param_reg <= param_next;
        end
    end

endmodule

>>> src/clp_skid.sv
// Result register with one skid entry between the parser and the output stream.
module clp_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  clp_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output clp_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    clp_pkg::result_t out_data_reg;
    clp_pkg::result_t skid_data_reg;
    logic             load_out;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load_out  = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        else if (in_valid && !skid_valid_reg)
            skid_data_reg <= in_data;
    end

endmodule

>>> src/ascii_command_line_parser_core.sv
// Top level: ASCII command line parser with streaming byte input and result output.
// One byte is taken per clock while s_tready is high; a CR LF pair closes the line
// and its result word (status, command, action, parameter) is registered onto m_tdata.
// The result side is a result register plus one skid entry, so s_tready drops only when
// two results are waiting; any byte that breaks the NAME->ACTION=DIGITS grammar restarts
// the parse at the next byte, and the bytes before it give no result.
module ascii_command_line_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [5:2] command, [9:6] action,
                                   // [40:10] parameter_res, [47:41] zero
);

    logic             accept;
    logic             emit;
    clp_pkg::result_t line_res;
    clp_pkg::result_t out_res;

    assign accept = s_tvalid && s_tready;

    clp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .emit    (emit),
        .result  (line_res)
    );

    clp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && emit),
        .in_ready  (s_tready),
        .in_data   (line_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'b0, out_res.parameter_res, out_res.action, out_res.command,
                      out_res.status};

`ifndef SYNTHESIS
    a_full_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("skid full without pending result");

    a_line_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> m_tvalid)
        else $error("line end did not produce a result word");

    a_bad_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.status == clp_pkg::ST_BAD_CMD) |->
        (out_res.command == 4'd0 && out_res.action == 4'd0 &&
         out_res.parameter_res == '0))
        else $error("unknown command carries nonzero fields");

    a_bad_act_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.status == clp_pkg::ST_BAD_ACT) |->
        (out_res.action == 4'd0 && out_res.parameter_res == '0))
        else $error("unknown action carries nonzero fields");

    a_codes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_res.command < 4'd13 && out_res.action < 4'd9 &&
                      out_res.status != 2'd3))
        else $error("result code out of range");
`endif

endmodule
